// ----- sv/lddr_pkg.sv -----
`default_nettype none

package lddr_pkg;

    // Command codes carried in the mode field
    typedef enum logic [2:0] {
        MODE_TICK     = 3'd0,
        MODE_WRITE    = 3'd1,
        MODE_REFRESH  = 3'd2,
        MODE_DISP_ON  = 3'd3,
        MODE_DISP_OFF = 3'd4,
        MODE_CLEAR    = 3'd5,
        MODE_ALL_ON   = 3'd6
    } mode_t;

    // Line sequencer phases, one-hot
    typedef enum logic [10:0] {
        PH_IDLE = 11'b000_0000_0001,
        PH_S1   = 11'b000_0000_0010,
        PH_S2   = 11'b000_0000_0100,
        PH_B0   = 11'b000_0000_1000,
        PH_B1   = 11'b000_0001_0000,
        PH_A0   = 11'b000_0010_0000,
        PH_A1   = 11'b000_0100_0000,
        PH_A2   = 11'b000_1000_0000,
        PH_P0   = 11'b001_0000_0000,
        PH_P1   = 11'b010_0000_0000,
        PH_P2   = 11'b100_0000_0000
    } phase_t;

    // Configuration register indexes
    localparam int          CFG_ADDR_W  = 1;
    localparam int          CFG_DATA_W  = 24;
    localparam logic [0:0]  CFG_UNIT    = 1'b0;
    localparam logic [0:0]  CFG_ACK_GAP = 1'b1;

    // Bytes sent on the link
    localparam logic [7:0] CMD_DATA_AUTO = 8'h40;
    localparam logic [7:0] CMD_ADDR_0    = 8'hC0;
    localparam logic [7:0] CMD_DISP_ON   = 8'h8F;
    localparam logic [7:0] CMD_DISP_OFF  = 8'h80;
    localparam logic [7:0] SEG_ALL_ON    = 8'hFF;
    localparam logic [7:0] SEG_CLEAR     = 8'h00;

    // Reset values of the timing registers
    localparam logic [15:0] UNIT_RESET = 16'd100;
    localparam logic [23:0] GAP_RESET  = 24'd100000;

    typedef struct packed {
        logic                  we;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_DATA_W-1:0] wdata;
    } cfg_t;

    // One result per tick
    typedef struct packed {
        logic rejected;
        logic busy_res;
        logic dio_drive;
        logic dio_level;
        logic clk_level;
    } res_t;

endpackage

`default_nettype wire

// ----- sv/led_driver_two_wire_refresh.sv -----
// Channel | Dir | Bits                                   | Transaction
// s_*     | in  | tdata: mode[2:0] idx[5:3] val[13:6]    | one clock tick, maybe a command
// m_*     | out | tdata: clk dio drive busy rejected [4:0]| line levels for that tick
// cfg_*   | in  | addr 0 unit_ticks, 1 ack_gap_ticks     | register write, no handshake
//
// One transaction accepted per cycle while s_tready is high; its result is registered and shown on m_*.
// Throughput is set by the two-entry output buffer: input stalls only when both
// entries are full. Reset clears the sequencer to idle, the digit store to 0xFF,
// the dwell unit to 100 ticks and the acknowledge gap to 100000 ticks.
// Line timing counts accepted transactions, not clock cycles.
`default_nettype none

module led_driver_two_wire_refresh
    import lddr_pkg::*;
#(
    parameter int DIGITS = 6
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [15:0]           s_tdata,   // mode, digit_index, digit_value
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [7:0]                 m_tdata,   // clk_level, dio_level, dio_drive,
                                                  // busy_res, rejected
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic accept;
    cfg_t cfg;
    res_t res, res_out;

    assign accept    = s_tvalid && s_tready;
    assign cfg.we    = cfg_we;
    assign cfg.addr  = cfg_addr;
    assign cfg.wdata = cfg_wdata;

    lddr_seq #(
        .DIGITS (DIGITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .accept      (accept),
        .mode        (s_tdata[2:0]),
        .digit_index (s_tdata[5:3]),
        .digit_value (s_tdata[13:6]),
        .result      (res)
    );

    lddr_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .din       (res),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .dout      (res_out)
    );

    assign m_tdata = {3'b000, res_out.rejected, res_out.busy_res, res_out.dio_drive,
                      res_out.dio_level, res_out.clk_level};

endmodule

`default_nettype wire

// ----- sv/lddr_seq.sv -----
`default_nettype none

module lddr_seq
    import lddr_pkg::*;
#(
    parameter int DIGITS = 6
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       accept,
    input  wire logic [2:0] mode,
    input  wire logic [2:0] digit_index,
    input  wire logic [7:0] digit_value,
    output res_t            result
);

    typedef struct packed {
        logic [1:0]  lines;
        logic [23:0] dwell;
    } ent_t;

    logic [15:0] unit_reg;
    logic [23:0] gap_reg;

    logic [7:0]  store_reg [DIGITS];
    logic [7:0]  store_next [DIGITS];
    phase_t      phase_reg, phase_c, phase_next;
    logic [23:0] dwell_reg, dwell_c, dwell_dec, dwell_next;
    logic [2:0]  bit_reg, bit_c, bit_next;
    logic [2:0]  byte_reg, byte_c, byte_next;
    logic [7:0]  shift_reg, shift_c, shift_next;
    logic [1:0]  lines_reg, lines_c, lines_next;
    logic        refresh_reg, refresh_c, refresh_next;
    logic        rej;

    logic [23:0] u2, u3, u5, gap1;
    logic [7:0]  rd_byte;
    logic [2:0]  rd_sel;
    phase_t      go_ph;
    logic        go_en;
    ent_t        e_cmd, e_fin;

    // Phase entry: line levels and dwell length
    function automatic ent_t enter_ph(phase_t ph, logic dio, logic bitv,
                                      logic [23:0] d2, logic [23:0] d3,
                                      logic [23:0] d5, logic [23:0] dg);
        ent_t e;
        e.lines = {1'b0, dio};
        e.dwell = '0;
        case (ph)
            PH_S1: begin e.lines = 2'b11;         e.dwell = d2;    end
            PH_S2: begin e.lines = 2'b10;         e.dwell = 24'd1; end
            PH_B0: begin e.lines = {1'b0, bitv};  e.dwell = d3;    end
            PH_B1: begin e.lines = {1'b1, bitv};  e.dwell = d3;    end
            PH_A0: begin e.lines = {1'b0, dio};   e.dwell = d5;    end
            PH_A1: begin e.lines = {1'b1, dio};   e.dwell = d2;    end
            PH_A2: begin e.lines = {1'b0, dio};   e.dwell = dg;    end
            PH_P0: begin e.lines = {1'b0, dio};   e.dwell = d2;    end
            PH_P1: begin e.lines = 2'b00;         e.dwell = d2;    end
            PH_P2: begin e.lines = 2'b10;         e.dwell = d2;    end
            default: ;
        endcase
        return e;
    endfunction

    // Dwell lengths in ticks, never below one
    always_comb
    begin
        if (unit_reg == '0)
        begin
            u2 = 24'd1;
            u3 = 24'd1;
            u5 = 24'd1;
        end
        else
        begin
            u2 = {7'd0, unit_reg, 1'b0};
            u3 = {8'd0, unit_reg} + {7'd0, unit_reg, 1'b0};
            u5 = {8'd0, unit_reg} + {6'd0, unit_reg, 2'b00};
        end
        gap1 = (gap_reg == '0) ? 24'd1 : gap_reg;
    end

    // Command stage: store updates, frame start, and rejection of frame commands while busy
    always_comb
    begin
        store_next = store_reg;
        phase_c    = phase_reg;
        dwell_c    = dwell_reg;
        bit_c      = bit_reg;
        byte_c     = byte_reg;
        shift_c    = shift_reg;
        lines_c    = lines_reg;
        refresh_c  = refresh_reg;
        rej        = 1'b0;
        e_cmd      = enter_ph(PH_S1, lines_reg[0], 1'b0, u2, u3, u5, gap1);
        case (mode_t'(mode))
            MODE_WRITE:
            begin
                for (int i = 0; i < DIGITS; i++)
                begin
                    if (digit_index == 3'(i))
                        store_next[i] = digit_value;
                end
            end
            MODE_CLEAR:
            begin
                for (int i = 0; i < DIGITS; i++)
                    store_next[i] = SEG_CLEAR;
            end
            MODE_ALL_ON:
            begin
                for (int i = 0; i < DIGITS; i++)
                    store_next[i] = SEG_ALL_ON;
            end
            MODE_REFRESH, MODE_DISP_ON, MODE_DISP_OFF:
            begin
                if (phase_reg != PH_IDLE)
                    rej = 1'b1;
                else
                begin
                    refresh_c = (mode_t'(mode) == MODE_REFRESH);
                    byte_c    = '0;
                    bit_c     = '0;
                    case (mode_t'(mode))
                        MODE_REFRESH: shift_c = CMD_DATA_AUTO;
                        MODE_DISP_ON: shift_c = CMD_DISP_ON;
                        default:      shift_c = CMD_DISP_OFF;
                    endcase
                    phase_c = PH_S1;
                    lines_c = e_cmd.lines;
                    dwell_c = e_cmd.dwell;
                end
            end
            default: ;
        endcase
    end

    // Lines as seen this tick
    always_comb
    begin
        result.clk_level = lines_c[1];
        result.dio_level = lines_c[0];
        result.dio_drive = !(phase_c inside {PH_A0, PH_A1, PH_A2});
        result.busy_res  = (phase_c != PH_IDLE);
        result.rejected  = rej;
    end

    // Digit byte read for the next transmission, after this tick's write
    always_comb
    begin
        rd_sel  = byte_c - 3'd1;
        rd_byte = store_next[0];
        for (int i = 0; i < DIGITS; i++)
        begin
            if (rd_sel == 3'(i))
                rd_byte = store_next[i];
        end
    end

    // Dwell countdown and phase advance
    always_comb
    begin
        phase_next   = phase_c;
        bit_next     = bit_c;
        byte_next    = byte_c;
        shift_next   = shift_c;
        lines_next   = lines_c;
        refresh_next = refresh_c;
        dwell_dec    = (dwell_c != '0) ? dwell_c - 24'd1 : dwell_c;
        dwell_next   = dwell_c;
        go_ph        = PH_IDLE;
        go_en        = 1'b0;
        if (phase_c != PH_IDLE)
        begin
            dwell_next = dwell_dec;
            if (dwell_dec == '0)
            begin
                go_en = 1'b1;
                case (phase_c)
                    PH_S1: go_ph = PH_S2;
                    PH_S2:
                    begin
                        bit_next = '0;
                        go_ph    = PH_B0;
                    end
                    PH_B0: go_ph = PH_B1;
                    PH_B1:
                    begin
                        if (bit_c == 3'd7)
                            go_ph = PH_A0;
                        else
                        begin
                            bit_next = bit_c + 3'd1;
                            go_ph    = PH_B0;
                        end
                    end
                    PH_A0: go_ph = PH_A1;
                    PH_A1: go_ph = PH_A2;
                    PH_A2:
                    begin
                        if (refresh_c && byte_c != '0 && 4'(byte_c) < 4'(DIGITS + 1))
                        begin
                            byte_next  = byte_c + 3'd1;
                            shift_next = rd_byte;
                            bit_next   = '0;
                            go_ph      = PH_B0;
                        end
                        else
                            go_ph = PH_P0;
                    end
                    PH_P0: go_ph = PH_P1;
                    PH_P1: go_ph = PH_P2;
                    PH_P2:
                    begin
                        lines_next = 2'b11;
                        if (refresh_c && byte_c == '0)
                        begin
                            byte_next  = 3'd1;
                            shift_next = CMD_ADDR_0;
                            go_ph      = PH_S1;
                        end
                        else
                        begin
                            go_en        = 1'b0;
                            refresh_next = 1'b0;
                            phase_next   = PH_IDLE;
                            dwell_next   = '0;
                        end
                    end
                    default:
                    begin
                        go_en      = 1'b0;
                        phase_next = PH_IDLE;
                        dwell_next = '0;
                    end
                endcase
            end
        end
        e_fin = enter_ph(go_ph, lines_c[0], shift_next[bit_next], u2, u3, u5, gap1);
        if (go_en)
        begin
            phase_next = go_ph;
            lines_next = e_fin.lines;
            dwell_next = e_fin.dwell;
        end
    end

    // Timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg <= UNIT_RESET;
            gap_reg  <= GAP_RESET;
        end
        else if (cfg.we)
        begin
            case (cfg.addr)
                CFG_UNIT:    unit_reg <= cfg.wdata[15:0];
                CFG_ACK_GAP: gap_reg  <= cfg.wdata;
                default: ;
            endcase
        end
    end

    // Sequencer state, advanced once per accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGITS; i++)
                store_reg[i] <= SEG_ALL_ON;
            phase_reg   <= PH_IDLE;
            dwell_reg   <= '0;
            bit_reg     <= '0;
            byte_reg    <= '0;
            shift_reg   <= '0;
            lines_reg   <= '0;
            refresh_reg <= 1'b0;
        end
        else if (accept)
        begin
            store_reg   <= store_next;
            phase_reg   <= phase_next;
            dwell_reg   <= dwell_next;
            bit_reg     <= bit_next;
            byte_reg    <= byte_next;
            shift_reg   <= shift_next;
            lines_reg   <= lines_next;
            refresh_reg <= refresh_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/lddr_obuf.sv -----
`default_nettype none

module lddr_obuf
    import lddr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire res_t din,
    output logic      ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output res_t      dout
);

    res_t main_reg, skid_reg;
    logic main_valid_reg, skid_valid_reg;
    logic pop;

    assign pop       = main_valid_reg && out_ready;
    assign ready     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign dout      = main_reg;

    // Result register with one skid entry behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
                skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
                skid_valid_reg <= 1'b1;
            else
                main_valid_reg <= 1'b1;
        end
        else if (pop)
            main_valid_reg <= 1'b0;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
                main_reg <= skid_reg;
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
                skid_reg <= din;
            else
                main_reg <= din;
        end
    end

endmodule

`default_nettype wire

// ----- sv/lddr_chk.sv -----
`default_nettype none

module lddr_chk
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata
);

    // Input only stalls when a result is waiting
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

    // After every accepted transaction a result is valid next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted transaction produced no result");

    // Released data line only inside a frame
    a_release_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[2]) |-> m_tdata[3])
        else $error("data line released while idle");

    // A dropped command always coincides with a frame in flight
    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[4]) |-> m_tdata[3])
        else $error("command rejected while idle");

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed under stall");

endmodule

bind led_driver_two_wire_refresh lddr_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
